// ----- rtl/tts_pkg.sv -----
`timescale 1ns / 1ps

package tts_pkg;

	localparam int HANDLE_W    = 16;
	localparam int TICKS_W     = 29;
	localparam int MS_W        = 32;
	localparam int PEND_W      = 8;
	localparam int SLOT_OUT_W  = 5;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	// Division by ten of a 32-bit value: floor(x * RECIP_10 / 2^RECIP_SHIFT).
	localparam logic [MS_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int              RECIP_SHIFT = 35;
	localparam int              PROD_W      = 2 * MS_W;

	localparam logic [PEND_W-1:0] PEND_MAX = '1;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_DELETE   = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_DISPATCH = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		ST_ADDED       = 3'd0,
		ST_FULL        = 3'd1,
		ST_DELETED     = 3'd2,
		ST_BAD_SLOT    = 3'd3,
		ST_TICK_DONE   = 3'd4,
		ST_RUN         = 3'd5,
		ST_NONE_READY  = 3'd6,
		ST_ZERO_HANDLE = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_MD,
		S_ADD_MP,
		S_ADD_SRCH,
		S_TICK,
		S_DSP,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TICKS_W-1:0]  delay;
		logic [TICKS_W-1:0]  period;
		logic [PEND_W-1:0]   pending;
	} entry_t;

endpackage

// ----- rtl/tts_ifs.sv -----
`timescale 1ns / 1ps

interface tts_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] task_handle;
	logic [31:0] delay_ms;
	logic [31:0] period_ms;
	logic [7:0]  slot_number;

	modport source(output valid, command, task_handle, delay_ms, period_ms, slot_number,
		input ready);
	modport sink(input valid, command, task_handle, delay_ms, period_ms, slot_number,
		output ready);
endinterface

interface tts_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  slot_index;
	logic [15:0] run_handle;
	logic        last;

	modport source(output valid, status, slot_index, run_handle, last, input ready);
	modport sink(input valid, status, slot_index, run_handle, last, output ready);
endinterface

// ----- rtl/tick_task_scheduler_table_unit.sv -----
`timescale 1ns / 1ps
// Tick-driven task scheduler table.
// Commands arrive on cmd (valid/ready); every beat there yields one or more
// result beats on res, the final one of each command marked by last.
// Add, delete, tick and dispatch work on a table of NUM_SLOTS slots kept in
// a single-port-write memory with a registered read; a bit per slot marks it
// occupied, so reset empties the table at once and needs no clearing pass.
// One command is in progress at a time; cmd.ready is high only when idle.
// Delete and a zero-handle add are answered from idle without a walk.
// An add walks from slot 0 to the first free slot, or all slots when full;
// tick walks every slot, one slot read-modify-written per cycle; dispatch
// walks the slots and may stop early at MAX_RESULTS run results.
// Before its walk, an add uses the shared 32x32 multiplier that divides
// the delay and then the period by ten.
// Results leave through an output register, so the next command is taken
// while a finished result waits. When res.ready stays low, a walk that must
// hand over another result pauses on the current slot until the beat goes.
// Reset (arst_n low) empties all slots and drops any pending result.

module tick_task_scheduler_table_unit #(
	parameter int NUM_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tts_cmd_if.sink   cmd,
	tts_res_if.source res
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SW = $clog2(NUM_SLOTS + 1);

	typedef struct packed {
		tts_pkg::status_t             status;
		logic [SW-1:0]                slot;
		logic [tts_pkg::HANDLE_W-1:0] handle;
	} result_t;

	typedef struct packed {
		logic    ld;
		result_t r;
		logic    last;
	} out_ctl_t;

	tts_pkg::state_t state_q, state_nxt;

	tts_pkg::entry_t slot_mem_q [NUM_SLOTS];
	tts_pkg::entry_t rd_s1;
	logic [NUM_SLOTS-1:0] valid_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] rd_addr;
	logic          idx_last;

	logic [tts_pkg::HANDLE_W-1:0] handle_q;
	logic [tts_pkg::MS_W-1:0]     dly_in_q;
	logic [tts_pkg::MS_W-1:0]     per_in_q;
	logic [tts_pkg::PROD_W-1:0]   prod_q;
	logic [tts_pkg::TICKS_W-1:0]  dq_q;
	logic [tts_pkg::TICKS_W-1:0]  quot;

	result_t                 pend_q;
	logic                    held_q;
	logic [tts_pkg::CNT_W-1:0] cnt_q;

	logic                         out_valid_q;
	result_t                      out_q;
	logic                         out_last_q;
	logic                         out_free;

	tts_pkg::command_t cmd_code;
	tts_pkg::entry_t   cur;
	logic              acc;

	// Control from the datapath control block.
	logic            adv;
	logic            walk_done;
	logic            add_found;
	logic            wr_en;
	tts_pkg::entry_t wr_data;
	logic            vset, vclr;
	logic [IW-1:0]   vaddr;
	logic            pend_ld;
	result_t         pend_nxt;
	out_ctl_t        octl;

	assign cmd_code = tts_pkg::command_t'(cmd.command);
	assign acc      = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == tts_pkg::S_IDLE);
	assign out_free  = !out_valid_q || res.ready;
	assign idx_last  = (idx_q == IW'(NUM_SLOTS - 1));
	assign cur       = valid_q[idx_q] ? rd_s1 : '0;
	assign quot      = prod_q[tts_pkg::RECIP_SHIFT +: tts_pkg::TICKS_W];

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tts_pkg::S_IDLE: begin
				if (acc) begin
					unique case (cmd_code)
						tts_pkg::CMD_ADD:
							state_nxt = (cmd.task_handle == '0) ? tts_pkg::S_EMIT
								: tts_pkg::S_ADD_MD;
						tts_pkg::CMD_DELETE:   state_nxt = tts_pkg::S_EMIT;
						tts_pkg::CMD_TICK:     state_nxt = tts_pkg::S_TICK;
						tts_pkg::CMD_DISPATCH: state_nxt = tts_pkg::S_DSP;
						default:               state_nxt = tts_pkg::S_IDLE;
					endcase
				end
			end
			tts_pkg::S_ADD_MD: state_nxt = tts_pkg::S_ADD_MP;
			tts_pkg::S_ADD_MP: state_nxt = tts_pkg::S_ADD_SRCH;
			tts_pkg::S_ADD_SRCH: begin
				if (add_found && out_free)
					state_nxt = tts_pkg::S_IDLE;
				else if (walk_done)
					state_nxt = tts_pkg::S_EMIT;
			end
			tts_pkg::S_TICK,
			tts_pkg::S_DSP: begin
				if (walk_done)
					state_nxt = tts_pkg::S_EMIT;
			end
			tts_pkg::S_EMIT: begin
				if (out_free)
					state_nxt = tts_pkg::S_IDLE;
			end
			default: state_nxt = tts_pkg::S_IDLE;
		endcase
	end

	// Datapath control.
	always_comb begin
		adv       = 1'b0;
		walk_done = 1'b0;
		add_found = 1'b0;
		wr_en     = 1'b0;
		wr_data   = cur;
		vset      = 1'b0;
		vclr      = 1'b0;
		vaddr     = idx_q;
		pend_ld   = 1'b0;
		pend_nxt  = '{status: tts_pkg::ST_TICK_DONE, slot: SW'(NUM_SLOTS), handle: '0};
		octl      = '{ld: 1'b0, r: pend_q, last: 1'b1};
		rd_addr   = '0;

		unique case (state_q)
			tts_pkg::S_IDLE: begin
				if (acc) begin
					unique case (cmd_code)
						tts_pkg::CMD_ADD: begin
							pend_ld         = 1'b1;
							pend_nxt.status = tts_pkg::ST_ZERO_HANDLE;
						end
						tts_pkg::CMD_DELETE: begin
							pend_ld = 1'b1;
							if (32'(cmd.slot_number) >= NUM_SLOTS) begin
								pend_nxt.status = tts_pkg::ST_BAD_SLOT;
							end else begin
								pend_nxt.status = tts_pkg::ST_DELETED;
								pend_nxt.slot   = SW'(cmd.slot_number);
								vclr            = 1'b1;
								vaddr           = IW'(cmd.slot_number);
							end
						end
						default: ;
					endcase
				end
			end
			tts_pkg::S_ADD_SRCH: begin
				if (!valid_q[idx_q]) begin
					add_found = 1'b1;
					if (out_free) begin
						wr_en   = 1'b1;
						wr_data = '{handle: handle_q, delay: dq_q, period: quot, pending: '0};
						vset    = 1'b1;
						octl    = '{ld: 1'b1,
							r: '{status: tts_pkg::ST_ADDED, slot: SW'(idx_q), handle: '0},
							last: 1'b1};
					end
				end else begin
					adv = 1'b1;
					if (idx_last) begin
						walk_done       = 1'b1;
						pend_ld         = 1'b1;
						pend_nxt.status = tts_pkg::ST_FULL;
					end
				end
			end
			tts_pkg::S_TICK: begin
				adv   = 1'b1;
				wr_en = valid_q[idx_q];
				if (cur.delay == '0) begin
					if (cur.pending != tts_pkg::PEND_MAX)
						wr_data.pending = cur.pending + 1'b1;
					if (cur.period != '0)
						wr_data.delay = cur.period;
				end else begin
					wr_data.delay = cur.delay - 1'b1;
				end
				if (idx_last) begin
					walk_done = 1'b1;
					pend_ld   = 1'b1;
				end
				rd_addr = idx_last ? '0 : idx_q + 1'b1;
			end
			tts_pkg::S_DSP: begin
				// The previous run result is held back until the next one is found,
				// so that the final beat can carry last.
				adv = !(cur.pending != '0 && held_q && !out_free);
				if (adv && cur.pending != '0) begin
					octl    = '{ld: held_q, r: pend_q, last: 1'b0};
					pend_ld = 1'b1;
					pend_nxt = '{status: tts_pkg::ST_RUN, slot: SW'(idx_q), handle: cur.handle};
					if (cur.period == '0) begin
						vclr = 1'b1;
					end else begin
						wr_en           = 1'b1;
						wr_data.pending = cur.pending - 1'b1;
					end
					if (idx_last || (cnt_q + 1'b1 == tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS)))
						walk_done = 1'b1;
				end else if (adv && idx_last) begin
					walk_done = 1'b1;
					if (!held_q) begin
						pend_ld         = 1'b1;
						pend_nxt.status = tts_pkg::ST_NONE_READY;
					end
				end
				if (walk_done)
					rd_addr = '0;
				else if (adv)
					rd_addr = idx_q + 1'b1;
				else
					rd_addr = idx_q;
			end
			tts_pkg::S_EMIT: begin
				octl = '{ld: out_free, r: pend_q, last: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tts_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Slot memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			slot_mem_q[idx_q] <= wr_data;
		rd_s1 <= slot_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (vset)
				valid_q[vaddr] <= 1'b1;
			else if (vclr)
				valid_q[vaddr] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			held_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (state_q == tts_pkg::S_IDLE || state_q == tts_pkg::S_ADD_MD) begin
				idx_q  <= '0;
				held_q <= 1'b0;
				cnt_q  <= '0;
			end else if (adv && !walk_done) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == tts_pkg::S_DSP && pend_ld && pend_nxt.status == tts_pkg::ST_RUN) begin
				held_q <= 1'b1;
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

	// Command capture, shared multiplier (delay first, then period) and pending result.
	always_ff @(posedge clk) begin
		if (acc) begin
			handle_q <= cmd.task_handle;
			dly_in_q <= cmd.delay_ms;
			per_in_q <= cmd.period_ms;
		end
		if (state_q == tts_pkg::S_ADD_MD || state_q == tts_pkg::S_ADD_MP)
			prod_q <= tts_pkg::PROD_W'(state_q == tts_pkg::S_ADD_MD ? dly_in_q : per_in_q)
				* tts_pkg::PROD_W'(tts_pkg::RECIP_10);
		if (state_q == tts_pkg::S_ADD_MP)
			dq_q <= quot;
		if (pend_ld)
			pend_q <= pend_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (octl.ld) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (octl.ld) begin
			out_q      <= octl.r;
			out_last_q <= octl.last;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.status     = out_q.status;
	assign res.slot_index = tts_pkg::SLOT_OUT_W'(out_q.slot);
	assign res.run_handle = out_q.handle;
	assign res.last       = out_last_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != tts_pkg::S_IDLE)
		else $error("command accepted but sequencer stayed idle");

	a_run_has_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == tts_pkg::ST_RUN) |-> out_q.handle != '0)
		else $error("run result carries an empty handle");

	a_handle_only_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != tts_pkg::ST_RUN) |-> out_q.handle == '0)
		else $error("non-run result carries a handle");

	a_run_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS))
		else $error("dispatch emitted more run results than allowed");

endmodule
